// ===== rtl/sdta_pkg.sv =====
package sdta_pkg;

    // Conversion geometry
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned NUM_STEPS  = 64;
    localparam int unsigned NUM_DIGITS = 20;
    localparam int unsigned STEP_W     = 6;
    localparam int unsigned REMAIN_W   = 5;

    // Character codes
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } sdta_state_t;

    // Per-cycle command broadcast to every digit cell
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } sdta_cell_ctrl_t;

endpackage

// ===== rtl/sdta_digit_cell.sv =====
module sdta_digit_cell (
    input  logic                     aclk,
    input  sdta_pkg::sdta_cell_ctrl_t ctrl,
    input  logic                     lsb_in,
    input  logic [3:0]               digit_in,
    output logic                     msb_out,
    output logic [3:0]               digit_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Add three when the digit would overflow after doubling
    always_comb begin
        if (digit_reg >= 4'd5) begin
            adj = digit_reg + 4'd3;
        end else begin
            adj = digit_reg;
        end
    end

    assign msb_out   = adj[3];
    assign digit_out = digit_reg;

    // Select clear, shift-in of one binary bit, move the digit up the row, or hold
    always_comb begin
        if (ctrl.clear) begin
            digit_next = 4'd0;
        end else if (ctrl.dabble) begin
            digit_next = {adj[2:0], lsb_in};
        end else if (ctrl.shift) begin
            digit_next = digit_in;
        end else begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Channel   Dir  Ports                                  Payload
// s_ (in)   in   s_valid, s_ready, s_value[63:0]        one signed integer
// m_ (out)  out  m_valid, m_ready, m_text_char, m_is_last  one ASCII character
//
// An item is accepted, shifted into the double-dabble row of 20 BCD cells
// (one binary bit per cycle), its leading zero digits are dropped, the first
// printed digit is found, a '-' is emitted for a negative value and then each
// printed digit; no new item is taken until the last digit is loaded.
// s_ready is high only in idle.
// Reset (aresetn, synchronous, active low) clears the sequencer and m_valid.
// A low m_ready with m_valid high holds the character register and pauses emission.
module signed_int_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_text_char,
    output logic        m_is_last
);

    localparam int unsigned ND = sdta_pkg::NUM_DIGITS;

    sdta_pkg::sdta_state_t     state_reg, state_next;
    logic [63:0]               mag_reg, mag_next;
    logic                      neg_reg, neg_next;
    logic [sdta_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [sdta_pkg::REMAIN_W-1:0] remain_reg, remain_next;
    logic                      m_valid_reg, m_valid_next;
    logic [7:0]                m_text_char_reg, m_text_char_next;
    logic                      m_is_last_reg, m_is_last_next;

    sdta_pkg::sdta_cell_ctrl_t cell_ctrl;
    logic                      slot_free;
    logic                      load;
    logic [3:0]                top_digit;

    logic       carry_w [ND+1];
    logic [3:0] digit_w [ND+1];

    // Feed the row: binary MSB into the lowest cell, zeros into the vacated digit
    assign carry_w[0] = mag_reg[63];
    assign digit_w[0] = 4'd0;

    for (genvar i = 0; i < ND; i++) begin : g_cell
        sdta_digit_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .lsb_in    (carry_w[i]),
            .digit_in  (digit_w[i]),
            .msb_out   (carry_w[i+1]),
            .digit_out (digit_w[i+1])
        );
    end

    assign top_digit = digit_w[ND];
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == sdta_pkg::ST_IDLE);

    // Sequence conversion, leading-zero drop and character emission
    always_comb begin
        state_next       = state_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        step_next        = step_reg;
        remain_next      = remain_reg;
        cell_ctrl        = '0;
        load             = 1'b0;
        m_text_char_next = m_text_char_reg;
        m_is_last_next   = m_is_last_reg;
        case (state_reg)
            sdta_pkg::ST_IDLE: begin
                if (s_valid) begin
                    neg_next        = s_value[63];
                    mag_next        = s_value[63] ? (64'd0 - s_value) : s_value;
                    step_next       = '0;
                    cell_ctrl.clear = 1'b1;
                    state_next      = sdta_pkg::ST_CONV;
                end
            end
            sdta_pkg::ST_CONV: begin
                cell_ctrl.dabble = 1'b1;
                mag_next         = {mag_reg[62:0], 1'b0};
                step_next        = step_reg + 1'b1;
                if (step_reg == sdta_pkg::STEP_W'(sdta_pkg::NUM_STEPS - 1)) begin
                    remain_next = sdta_pkg::REMAIN_W'(ND);
                    state_next  = sdta_pkg::ST_SKIP;
                end
            end
            sdta_pkg::ST_SKIP: begin
                if (top_digit == 4'd0 && remain_reg > sdta_pkg::REMAIN_W'(1)) begin
                    cell_ctrl.shift = 1'b1;
                    remain_next     = remain_reg - 1'b1;
                end else if (neg_reg) begin
                    state_next = sdta_pkg::ST_SIGN;
                end else begin
                    state_next = sdta_pkg::ST_EMIT;
                end
            end
            sdta_pkg::ST_SIGN: begin
                if (slot_free) begin
                    load             = 1'b1;
                    m_text_char_next = sdta_pkg::ASCII_MINUS;
                    m_is_last_next   = 1'b0;
                    state_next       = sdta_pkg::ST_EMIT;
                end
            end
            sdta_pkg::ST_EMIT: begin
                if (slot_free) begin
                    load             = 1'b1;
                    m_text_char_next = sdta_pkg::ASCII_ZERO + {4'd0, top_digit};
                    m_is_last_next   = (remain_reg == sdta_pkg::REMAIN_W'(1));
                    cell_ctrl.shift  = 1'b1;
                    remain_next      = remain_reg - 1'b1;
                    if (remain_reg == sdta_pkg::REMAIN_W'(1)) begin
                        state_next = sdta_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sdta_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the character until taken, drop valid once it goes
    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sdta_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg         <= mag_next;
        neg_reg         <= neg_next;
        step_reg        <= step_next;
        remain_reg      <= remain_next;
        m_text_char_reg <= m_text_char_next;
        m_is_last_reg   <= m_is_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_text_char = m_text_char_reg;
    assign m_is_last   = m_is_last_reg;

    // Accepted item always starts the conversion
    a_accept_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == sdta_pkg::ST_CONV))
        else $error("accepted item did not start conversion");

    // The row never holds a non-decimal digit when it is printed
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sdta_pkg::ST_EMIT && slot_free) |-> (top_digit <= 4'd9))
        else $error("digit cell out of decimal range");

    // A minus sign is never the final character
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_text_char == sdta_pkg::ASCII_MINUS) |-> !m_is_last)
        else $error("minus sign flagged as last");

    // Conversion leaves after its last bit step
    a_conv_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sdta_pkg::ST_CONV &&
         step_reg == sdta_pkg::STEP_W'(sdta_pkg::NUM_STEPS - 1))
        |=> (state_reg == sdta_pkg::ST_SKIP))
        else $error("conversion overran its step count");

endmodule
